/* hw/rtl/h264_nal_pkg.sv */
// Package for the Annex B NAL splitter: command codes, byte constants and the
// result and group word types shared by the front, the queue and the back end.
// No dependencies.
package h264_nal_pkg;

  typedef enum logic {
    CMD_DATA  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  localparam logic [7:0] START_BYTE    = 8'h01;
  localparam logic [7:0] EPB_BYTE      = 8'h03;
  localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
  localparam logic [1:0] ZERO_RUN_MAX  = 2'd3;
  localparam int unsigned GRP_SLOTS    = 3;
  localparam int unsigned QUEUE_DEPTH  = 4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [4:0] nal_type;
    logic       first_of_nal;
    logic       last_of_nal;
  } res_t;

  typedef struct packed {
    logic [1:0]                 cnt;
    res_t [GRP_SLOTS-1:0]       res;
  } grp_t;

endpackage

/* hw/rtl/h264_nal_front.sv */
// Front end of the NAL splitter: parses one stream byte per accepted word and
// builds a group of up to three result words. Depends on h264_nal_pkg.
module h264_nal_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic                cmd_i,
  input  logic [7:0]          in_byte_i,
  output logic                grp_valid_o,
  output h264_nal_pkg::grp_t  grp_o
);
  import h264_nal_pkg::*;

  logic [7:0] held_byte_q, held_byte_d;
  logic       held_valid_q, held_valid_d;
  logic       held_hdr_q, held_hdr_d;
  logic [1:0] zero_run_q, zero_run_d;
  logic       inside_q, inside_d;
  logic       exp_hdr_q, exp_hdr_d;
  logic [4:0] cur_type_q, cur_type_d;

  grp_t       grp_d;
  logic [1:0] zr_inc;
  logic [1:0] nz;
  logic       keep;
  logic [2:0] push_v;
  logic [7:0] push_b [GRP_SLOTS];

  always_comb begin
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    held_hdr_d   = held_hdr_q;
    zero_run_d   = zero_run_q;
    inside_d     = inside_q;
    exp_hdr_d    = exp_hdr_q;
    cur_type_d   = cur_type_q;
    grp_d        = '0;
    zr_inc       = (zero_run_q == ZERO_RUN_MAX) ? ZERO_RUN_MAX : zero_run_q + 2'd1;
    nz           = (zero_run_q >= 2'd2) ? 2'd2 : zero_run_q;
    keep         = !((in_byte_i == EPB_BYTE) && (zero_run_q == 2'd2));
    push_v       = '0;
    for (int k = 0; k < GRP_SLOTS; k++) begin
      push_b[k] = '0;
    end

    if (cmd_i == CMD_FLUSH) begin
      if (inside_q && held_valid_q) begin
        grp_d.res[0] = '{held_byte_q, cur_type_q, held_hdr_q, 1'b1};
        grp_d.cnt    = 2'd1;
      end
      held_byte_d  = '0;
      held_valid_d = 1'b0;
      held_hdr_d   = 1'b0;
      zero_run_d   = '0;
      inside_d     = 1'b0;
      exp_hdr_d    = 1'b0;
      cur_type_d   = '0;
    end else if (in_byte_i == 8'h00) begin
      zero_run_d = zr_inc;
      if (inside_q && (zr_inc == ZERO_RUN_MAX)) begin
        if (held_valid_q) begin
          grp_d.res[0] = '{held_byte_q, cur_type_q, held_hdr_q, 1'b1};
          grp_d.cnt    = 2'd1;
        end
        held_valid_d = 1'b0;
        held_hdr_d   = 1'b0;
        inside_d     = 1'b0;
        exp_hdr_d    = 1'b0;
      end
    end else if ((in_byte_i == START_BYTE) && (zero_run_q >= 2'd2)) begin
      if (inside_q) begin
        if (held_valid_q) begin
          grp_d.res[0] = '{held_byte_q, cur_type_q, held_hdr_q, 1'b1};
          grp_d.cnt    = 2'd1;
        end
        held_valid_d = 1'b0;
        held_hdr_d   = 1'b0;
      end
      inside_d   = 1'b1;
      exp_hdr_d  = 1'b1;
      zero_run_d = '0;
    end else if (!inside_q) begin
      zero_run_d = '0;
    end else begin
      push_v[0] = (nz != 2'd0);
      push_v[1] = (nz == 2'd2);
      push_v[2] = keep;
      push_b[2] = in_byte_i;
      for (int k = 0; k < GRP_SLOTS; k++) begin
        if (push_v[k]) begin
          if (held_valid_d) begin
            grp_d.res[grp_d.cnt] = '{held_byte_d, cur_type_d, held_hdr_d, 1'b0};
            grp_d.cnt            = grp_d.cnt + 2'd1;
          end
          held_byte_d  = push_b[k];
          held_valid_d = 1'b1;
          held_hdr_d   = exp_hdr_d;
          if (exp_hdr_d) begin
            cur_type_d = push_b[k][4:0] & NAL_TYPE_MASK[4:0];
            exp_hdr_d  = 1'b0;
          end
        end
      end
      zero_run_d = '0;
    end
  end

  assign grp_valid_o = take_i && (grp_d.cnt != 2'd0);
  assign grp_o       = grp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      held_hdr_q   <= 1'b0;
      zero_run_q   <= '0;
      inside_q     <= 1'b0;
      exp_hdr_q    <= 1'b0;
      cur_type_q   <= '0;
    end else if (take_i) begin
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      held_hdr_q   <= held_hdr_d;
      zero_run_q   <= zero_run_d;
      inside_q     <= inside_d;
      exp_hdr_q    <= exp_hdr_d;
      cur_type_q   <= cur_type_d;
    end
  end

endmodule

/* hw/rtl/h264_nal_queue.sv */
// Short register queue of result groups between the front and the back end.
// Depends on h264_nal_pkg.
module h264_nal_queue #(
  parameter int unsigned Depth = h264_nal_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  h264_nal_pkg::grp_t  push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                pop_valid_o,
  output h264_nal_pkg::grp_t  pop_data_o
);
  import h264_nal_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  grp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* hw/rtl/h264_nal_back.sv */
// Back end of the NAL splitter: holds one result group in a register and
// sends its words one per cycle while ready. Depends on h264_nal_pkg.
module h264_nal_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                grp_valid_i,
  input  h264_nal_pkg::grp_t  grp_i,
  output logic                grp_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output h264_nal_pkg::res_t  out_o
);
  import h264_nal_pkg::*;

  grp_t       grp_q;
  logic       have_q, have_d;
  logic [1:0] idx_q, idx_d;
  logic       fire, end_of_grp;

  assign out_valid_o = have_q;
  assign out_o       = grp_q.res[idx_q];
  assign fire        = have_q && out_ready_i;
  assign end_of_grp  = (idx_q + 2'd1 == grp_q.cnt);
  assign grp_pop_o   = grp_valid_i && (!have_q || (fire && end_of_grp));

  always_comb begin
    have_d = have_q;
    idx_d  = idx_q;
    if (grp_pop_o) begin
      have_d = 1'b1;
      idx_d  = '0;
    end else if (fire) begin
      if (end_of_grp) begin
        have_d = 1'b0;
        idx_d  = '0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_pop_o) begin
      grp_q <= grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      have_q <= have_d;
      idx_q  <= idx_d;
    end
  end

endmodule

/* hw/rtl/h264_annexb_nal_splitter_top.sv */
// Top level of the H.264 Annex B NAL splitter: front parser, group queue and
// output serializer. Depends on h264_nal_pkg and the three h264_nal modules.
//
// The block takes one stream word per cycle and splits the byte stream at
// 00 00 01 start codes, drops emulation prevention bytes and sends NAL bytes
// with their type and first and last flags. One byte is held back until the
// next byte, start code, three zeros or a flush shows whether it ends its NAL.
// An input word makes up to three output words; they go out at one word per
// cycle while the output is ready, so the input side runs at one word per
// cycle if output keeps up on average, and stalls only when the group queue is full.
module h264_annexb_nal_splitter_top #(
  parameter int unsigned QueueDepth = h264_nal_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [12:8] nal_type, [15:13] zero
  output logic        m_axis_tuser,   // [0] first_of_nal
  output logic        m_axis_tlast    // last_of_nal
);
  import h264_nal_pkg::*;

  logic take;
  logic grp_valid, q_full, q_pop, q_valid;
  grp_t grp, q_data;
  res_t res;

  assign s_axis_tready = !q_full;
  assign take          = s_axis_tvalid && s_axis_tready;

  h264_nal_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .cmd_i       (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .grp_valid_o (grp_valid),
    .grp_o       (grp)
  );

  h264_nal_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (grp_valid),
    .push_data_i (grp),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_data)
  );

  h264_nal_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (q_valid),
    .grp_i       (q_data),
    .grp_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {3'b000, res.nal_type, res.out_byte};
  assign m_axis_tuser = res.first_of_nal;
  assign m_axis_tlast = res.last_of_nal;

endmodule

/* hw/rtl/h264_nal_checker.sv */
// Port-level checker for the NAL splitter and its bind to the top level.
// Depends on h264_annexb_nal_splitter_top only through the bind.
module h264_nal_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);
  logic       open_q;
  logic [4:0] type_q;
  logic       fire;

  assign fire = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      type_q <= '0;
    end else if (fire) begin
      open_q <= !m_axis_tlast;
      type_q <= m_axis_tdata[12:8];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_header_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[4:0] == m_axis_tdata[12:8])
    else $error("NAL type does not match header byte");

  a_nal_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !open_q |-> m_axis_tuser)
    else $error("NAL does not start with its header byte");

  a_nal_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && open_q |-> !m_axis_tuser && m_axis_tdata[12:8] == type_q)
    else $error("NAL body word breaks its NAL");

endmodule

bind h264_annexb_nal_splitter_top h264_nal_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

/* test/h264_annexb_nal_splitter_top_tb.sv */
// Self-checking testbench for h264_annexb_nal_splitter_top: directed and random Annex B streams
// are checked word by word against an in-bench model of the NAL splitter.
// Depends on h264_nal_pkg and the splitter RTL.
`timescale 1ns / 1ps

module h264_annexb_nal_splitter_top_tb;
  import h264_nal_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tuser  = CMD_DATA;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // Splitter model state.
  logic [7:0] held_byte  = 8'h00;
  logic       held_valid = 1'b0;
  logic       held_hdr   = 1'b0;
  logic [1:0] zero_run   = 2'd0;
  logic       in_nal     = 1'b0;
  logic       want_hdr   = 1'b0;
  logic [4:0] cur_type   = 5'd0;

  res_t nal_bytes_q[$];
  int   fail_cnt   = 0;
  int   words_sent = 0;
  int   bytes_seen = 0;
  int   nals_seen  = 0;
  int   burst_left = 0;
  int   rx_cycle   = 0;
  int   rx_stall   = 0;

  h264_annexb_nal_splitter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  task automatic emit_held(input logic last);
    res_t r;
    r.out_byte     = held_byte;
    r.nal_type     = cur_type;
    r.first_of_nal = held_hdr;
    r.last_of_nal  = last;
    nal_bytes_q.insert(nal_bytes_q.size(), r);
  endtask

  task automatic hold_byte(input logic [7:0] b);
    if (held_valid) begin
      emit_held(1'b0);
    end
    held_byte  = b;
    held_valid = 1'b1;
    held_hdr   = want_hdr;
    if (want_hdr) begin
      cur_type = b[4:0] & NAL_TYPE_MASK[4:0];
      want_hdr = 1'b0;
    end
  endtask

  task automatic close_held();
    if (held_valid) begin
      emit_held(1'b1);
    end
    held_valid = 1'b0;
    held_hdr   = 1'b0;
  endtask

  task automatic split_word(input cmd_e cmd, input logic [7:0] b);
    int k;
    if (cmd == CMD_FLUSH) begin
      if (in_nal) begin
        close_held();
      end
      held_byte  = 8'h00;
      held_valid = 1'b0;
      held_hdr   = 1'b0;
      zero_run   = 2'd0;
      in_nal     = 1'b0;
      want_hdr   = 1'b0;
      cur_type   = 5'd0;
    end else if (b == 8'h00) begin
      if (zero_run < ZERO_RUN_MAX) begin
        zero_run = zero_run + 2'd1;
      end
      if (in_nal && zero_run == ZERO_RUN_MAX) begin
        close_held();
        in_nal   = 1'b0;
        want_hdr = 1'b0;
      end
    end else if (b == START_BYTE && zero_run >= 2) begin
      if (in_nal) begin
        close_held();
      end
      in_nal   = 1'b1;
      want_hdr = 1'b1;
      zero_run = 2'd0;
    end else if (!in_nal) begin
      zero_run = 2'd0;
    end else begin
      for (k = 0; k < zero_run && k < 2; k++) begin
        hold_byte(8'h00);
      end
      if (!(b == EPB_BYTE && zero_run == 2)) begin
        hold_byte(b);
      end
      zero_run = 2'd0;
    end
  endtask

  task automatic compare_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fail_cnt++;
    end
  endtask

  // Input words feed the model before output words are checked at each clock edge.
  always @(posedge clk_i) begin
    res_t exp_w;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        split_word(cmd_e'(s_axis_tuser), s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        bytes_seen++;
        if (m_axis_tlast) begin
          nals_seen++;
        end
        if (nal_bytes_q.size() == 0) begin
          $error("Unexpected output word 0x%04h (first %0b, last %0b)",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fail_cnt++;
        end else begin
          exp_w = nal_bytes_q.pop_front();
          compare_field("out_byte", exp_w.out_byte, m_axis_tdata[7:0]);
          compare_field("nal_type", exp_w.nal_type, m_axis_tdata[12:8]);
          compare_field("first_of_nal", exp_w.first_of_nal, m_axis_tuser);
          compare_field("last_of_nal", exp_w.last_of_nal, m_axis_tlast);
        end
      end
    end
  end

  // The receiver cycles through always ready, random ready and long stalls.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[8:7])
      2'd0: begin
        m_axis_tready <= 1'b1;
      end
      2'd1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (rx_stall != 0) begin
          rx_stall      <= rx_stall - 1;
          m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_stall      <= $urandom_range(1, 11);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  task automatic send_word(input cmd_e cmd, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] bytes[$]);
    foreach (bytes[i]) begin
      send_word(CMD_DATA, bytes[i]);
    end
  endtask

  // Junk before the first start code, a zero header byte, emulation prevention
  // followed by a kept 03, three zeros ending a NAL, empty NALs, a four-byte
  // start code, and a flush with a byte still held.
  task automatic test_directed();
    send_bytes('{8'h55, 8'h00, 8'h00, 8'h01, 8'h00, 8'h05, 8'h00, 8'h00, 8'h03, 8'h03});
    send_bytes('{8'h00, 8'h00, 8'h00, 8'h42, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01});
    send_bytes('{8'h00, 8'h00, 8'h00, 8'h01, 8'hff, 8'h80});
    send_word(CMD_FLUSH, 8'($urandom));
  endtask

  task automatic test_random_streams();
    int target;
    int plen;
    int zeros;
    int sel;
    target = words_sent + 330;
    while (words_sent < target) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        repeat ($urandom_range(1, 4)) send_word(CMD_DATA, 8'($urandom));
      end else if (sel == 1) begin
        send_word(CMD_FLUSH, 8'($urandom));
      end
      zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : 2;
      repeat (zeros) send_word(CMD_DATA, 8'h00);
      send_word(CMD_DATA, START_BYTE);
      send_word(CMD_DATA, ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom));
      plen = $urandom_range(0, 12);
      repeat (plen) begin
        case ($urandom_range(0, 11))
          0, 1, 2: send_word(CMD_DATA, 8'h00);
          3:       send_word(CMD_DATA, EPB_BYTE);
          4:       send_word(CMD_DATA, START_BYTE);
          5: begin
            send_bytes('{8'h00, 8'h00, EPB_BYTE});
            send_word(CMD_DATA, 8'($urandom_range(0, 3)));
          end
          default: send_word(CMD_DATA, 8'($urandom));
        endcase
      end
    end
    send_word(CMD_FLUSH, 8'($urandom));
  endtask

  task automatic finish_run();
    s_axis_tvalid <= 1'b0;
    while (nal_bytes_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d stream words; checked %0d NAL bytes closing %0d NALs.",
             words_sent, bytes_seen, nals_seen);
    if (fail_cnt == 0) begin
      $display("** h264_annexb_nal_splitter_top: PASSED **");
    end else begin
      $display("** h264_annexb_nal_splitter_top: FAILED **");
    end
    $finish;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_streams();
    finish_run();
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d NAL bytes still expected.", nal_bytes_q.size());
    $display("** h264_annexb_nal_splitter_top: FAILED **");
    $finish;
  end

endmodule
